>>> design/bhp_pkg.sv
// ============================================================================
// bhp_pkg: shared definitions for the byte histogram block
// Sizes, operation codes, the queued item type and the state machine types.
// ============================================================================
package bhp_pkg;

    // Histogram sizes.
    localparam int SYMBOLS       = 256;
    localparam int COUNT_BITS    = 32;
    localparam int FRACTION_BITS = 16;

    // Address width of the bin store.
    localparam int SYM_AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    // Percentage scale; 100 fits in SCALE_BITS, and 100 * 2^F stays below 2^QUO_BITS.
    localparam int PCT_SCALE  = 100;
    localparam int SCALE_BITS = 7;
    localparam int QUO_BITS   = SCALE_BITS + FRACTION_BITS;
    localparam int DIVD_BITS  = COUNT_BITS + QUO_BITS;
    localparam int STEP_BITS  = $clog2(QUO_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [7:0]            DIST_MAX  = 8'hFF;
    localparam logic [QUO_BITS-1:0]   PCT_MAX   = QUO_BITS'(PCT_SCALE) << FRACTION_BITS;

    // Operation codes on the input port.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Item class after decode.
    typedef enum logic [1:0] {
        K_ADD,
        K_QUERY,
        K_CLEAR
    } kind_t;

    // One queued item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] symbol;
    } item_t;

    // Execution sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } back_state_t;

    // Divider states.
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_LOAD,
        DV_RUN,
        DV_DONE
    } div_state_t;

endpackage

>>> design/bhp_ram.sv
// ============================================================================
// bhp_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ============================================================================
module bhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/bhp_front.sv
// ============================================================================
// bhp_front: item intake, decode and queue
// Accepts items, classifies the operation code and holds up to two items
// for the execution side.
// ============================================================================
module bhp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           operation,
    input  logic [7:0]           symbol,
    output logic                 busy,
    output logic                 item_valid,
    output bhp_pkg::item_t       item,
    input  logic                 pop
);

    bhp_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    bhp_pkg::kind_t kind;
    logic           push;

    // Classify the operation; the unused code behaves as a query.
    always_comb
    begin
        unique case (operation)
            bhp_pkg::OP_ADD:   kind = bhp_pkg::K_ADD;
            bhp_pkg::OP_CLEAR: kind = bhp_pkg::K_CLEAR;
            default:           kind = bhp_pkg::K_QUERY;
        endcase
    end

    assign busy       = (fill_reg == 2'd2);
    assign push       = start && !busy;
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{kind: kind, symbol: symbol};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The execution side never takes an item from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> fill_reg != 2'd0)
        else $error("bhp_front: pop from empty queue");
`endif

endmodule

>>> design/bhp_div.sv
// ============================================================================
// bhp_div: percentage divider
// Computes floor(100 * count * 2^F / total) with a scaling multiply and a
// restoring divider that retires one quotient bit per cycle.
// ============================================================================
module bhp_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [bhp_pkg::COUNT_BITS-1:0]       count,
    input  logic [bhp_pkg::COUNT_BITS-1:0]       total,
    output logic                                 done,
    output logic [bhp_pkg::QUO_BITS-1:0]         quotient
);

    localparam int CB = bhp_pkg::COUNT_BITS;
    localparam int QB = bhp_pkg::QUO_BITS;

    bhp_pkg::div_state_t           state_reg, state_next;
    logic [CB-1:0]                 cnt_reg, cnt_next;
    logic [CB-1:0]                 den_reg, den_next;
    logic [CB-1:0]                 rem_reg, rem_next;
    logic [QB-1:0]                 quo_reg, quo_next;
    logic [bhp_pkg::STEP_BITS-1:0] step_reg, step_next;

    logic [CB+bhp_pkg::SCALE_BITS-1:0] product;
    logic [bhp_pkg::DIVD_BITS-1:0]     dividend;
    logic [CB:0]                       trial;
    logic [CB:0]                       diff;
    logic                              ge;

    // Scaling multiply and one restoring step.
    assign product  = cnt_reg * bhp_pkg::SCALE_BITS'(bhp_pkg::PCT_SCALE);
    assign dividend = bhp_pkg::DIVD_BITS'(product) << bhp_pkg::FRACTION_BITS;
    assign trial    = {rem_reg, quo_reg[QB-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});

    // A zero total gives a zero share.
    assign quotient = (den_reg == '0) ? '0 : quo_reg;

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        done       = 1'b0;
        unique case (state_reg)
            bhp_pkg::DV_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = count;
                    den_next   = total;
                    state_next = bhp_pkg::DV_LOAD;
                end
            end
            bhp_pkg::DV_LOAD:
            begin
                // The top bits are below the divisor because count never exceeds total.
                rem_next   = dividend[bhp_pkg::DIVD_BITS-1 -: CB];
                quo_next   = dividend[QB-1:0];
                step_next  = '0;
                state_next = bhp_pkg::DV_RUN;
            end
            bhp_pkg::DV_RUN:
            begin
                rem_next  = ge ? diff[CB-1:0] : trial[CB-1:0];
                quo_next  = {quo_reg[QB-2:0], ge};
                step_next = step_reg + bhp_pkg::STEP_BITS'(1);
                if (step_reg == bhp_pkg::STEP_BITS'(QB - 1))
                begin
                    state_next = bhp_pkg::DV_DONE;
                end
            end
            bhp_pkg::DV_DONE:
            begin
                done       = 1'b1;
                state_next = bhp_pkg::DV_IDLE;
            end
            default:
            begin
                state_next = bhp_pkg::DV_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhp_pkg::DV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

>>> design/bhp_back.sv
// ============================================================================
// bhp_back: histogram execution side
// Reads the addressed bin, applies add, query or clear, keeps the total and
// distinct counters, runs the divider and presents one result per item.
// ============================================================================
module bhp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  bhp_pkg::item_t        item,
    output logic                  pop,
    output logic                  done,
    output logic                  present,
    output logic [31:0]           bin_count,
    output logic [22:0]           percent_fixed,
    output logic [7:0]            distinct_symbols,
    output logic [31:0]           total_bytes
);

    localparam int CB = bhp_pkg::COUNT_BITS;
    localparam int AW = bhp_pkg::SYM_AW;

    bhp_pkg::back_state_t          state_reg, state_next;
    bhp_pkg::item_t                item_reg, item_next;
    logic [CB-1:0]                 total_reg, total_next;
    logic [7:0]                    dist_reg, dist_next;
    logic [bhp_pkg::SYMBOLS-1:0]   vld_reg, vld_next;
    logic                          vbit_reg, vbit_next;
    logic [CB-1:0]                 count_reg, count_next;
    logic                          done_reg, done_next;
    logic [bhp_pkg::QUO_BITS-1:0]  percent_reg, percent_next;

    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 cur_addr;
    logic [CB-1:0]                 rd_data;
    logic                          wr_en;
    logic [CB-1:0]                 old_count;
    logic                          sym_ok;
    logic                          div_start;
    logic                          div_done;
    logic [bhp_pkg::QUO_BITS-1:0]  div_quotient;

    bhp_ram #(
        .WIDTH (CB),
        .DEPTH (bhp_pkg::SYMBOLS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_addr),
        .wr_data (count_next),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (count_next),
        .total    (total_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Bin addressing; a bin that was never written since clear reads as zero.
    assign rd_addr   = item.symbol[AW-1:0];
    assign cur_addr  = item_reg.symbol[AW-1:0];
    assign sym_ok    = (int'(item_reg.symbol) < bhp_pkg::SYMBOLS);
    assign old_count = (vbit_reg && sym_ok) ? rd_data : '0;

    // Sequencer and counter updates.
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        total_next   = total_reg;
        dist_next    = dist_reg;
        vld_next     = vld_reg;
        vbit_next    = vbit_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        percent_next = percent_reg;
        pop          = 1'b0;
        wr_en        = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            bhp_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop        = 1'b1;
                    item_next  = item;
                    vbit_next  = vld_reg[rd_addr];
                    state_next = bhp_pkg::ST_EXEC;
                end
            end
            bhp_pkg::ST_EXEC:
            begin
                count_next = old_count;
                case (item_reg.kind)
                    bhp_pkg::K_ADD:
                    begin
                        // Byte zero and out-of-range symbols are not counted.
                        if (sym_ok && item_reg.symbol != 8'd0)
                        begin
                            if (old_count != bhp_pkg::COUNT_MAX)
                            begin
                                count_next = old_count + CB'(1);
                            end
                            if (total_reg != bhp_pkg::COUNT_MAX)
                            begin
                                total_next = total_reg + CB'(1);
                            end
                            if (old_count == '0 && dist_reg != bhp_pkg::DIST_MAX)
                            begin
                                dist_next = dist_reg + 8'd1;
                            end
                            wr_en              = 1'b1;
                            vld_next[cur_addr] = 1'b1;
                        end
                    end
                    bhp_pkg::K_CLEAR:
                    begin
                        vld_next   = '0;
                        total_next = '0;
                        dist_next  = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = old_count;
                    end
                endcase
                div_start  = 1'b1;
                state_next = bhp_pkg::ST_WAIT;
            end
            bhp_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    percent_next = div_quotient;
                    state_next   = bhp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bhp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhp_pkg::ST_IDLE;
            total_reg <= '0;
            dist_reg  <= '0;
            vld_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            dist_reg  <= dist_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        vbit_reg    <= vbit_next;
        count_reg   <= count_next;
        percent_reg <= percent_next;
    end

    // Result ports.
    assign done             = done_reg;
    assign present          = (count_reg != '0);
    assign bin_count        = 32'(count_reg);
    assign percent_fixed    = 23'(percent_reg);
    assign distinct_symbols = dist_reg;
    assign total_bytes      = 32'(total_reg);

`ifndef NO_ASSERTIONS
    // Every distinct symbol contributed at least one byte to the total.
    assert property (@(posedge clk) disable iff (!rst_n)
        CB'(dist_reg) <= total_reg)
        else $error("bhp_back: distinct count exceeds total");

    // A share never exceeds one hundred percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> percent_reg <= bhp_pkg::PCT_MAX)
        else $error("bhp_back: percentage above full scale");

    // The result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("bhp_back: result strobe held");

    // A clear empties the total and distinct counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhp_pkg::ST_EXEC && item_reg.kind == bhp_pkg::K_CLEAR)
        |=> (total_reg == '0 && dist_reg == 8'd0))
        else $error("bhp_back: clear left counts behind");
`endif

endmodule

>>> design/byte_histogram_percent.sv
// ============================================================================
// byte_histogram_percent: byte frequency histogram with percentage readout
// Counts nonzero bytes per value, keeps total and distinct counts, and
// reports a bin's count and its share of the total in fixed point.
// ============================================================================
//
// Channel   Handshake        Payload
// -------   --------------   ------------------------------------------------
// input     start / busy     operation, symbol
// result    done (strobe)    present, bin_count, percent_fixed,
//                            distinct_symbols, total_bytes
//
// Each item occupies the execution side for the bin read, the update and
// then the divider (a load state with the scaling multiply, 23 one-bit
// restoring steps and a finish state). The result strobe comes in the
// following cycle, which is also the bin read of the next queued item, so
// the execution side starts an item only when the last one is through. A
// two-item queue lets the input side accept items while the previous one
// executes; busy is high while it is full.
// Reset clears the counters and the bin valid bits at once, so no clearing
// pass is needed. Results cannot be stalled: each is shown for one cycle.
//
module byte_histogram_percent (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  symbol,
    output logic        done,
    output logic        present,
    output logic [31:0] bin_count,
    output logic [22:0] percent_fixed,
    output logic [7:0]  distinct_symbols,
    output logic [31:0] total_bytes
);

    logic           item_valid;
    bhp_pkg::item_t item;
    logic           pop;

    bhp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .symbol     (symbol),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    bhp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item             (item),
        .pop              (pop),
        .done             (done),
        .present          (present),
        .bin_count        (bin_count),
        .percent_fixed    (percent_fixed),
        .distinct_symbols (distinct_symbols),
        .total_bytes      (total_bytes)
    );

endmodule
